// ===== sv/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8dec_pkg;

	// Lead byte masks and prefixes
	localparam logic [7:0] MASK_ASCII = 8'h80;
	localparam logic [7:0] PFX_ASCII  = 8'h00;
	localparam logic [7:0] MASK_LEAD2 = 8'hE0;
	localparam logic [7:0] PFX_LEAD2  = 8'hC0;
	localparam logic [7:0] MASK_LEAD3 = 8'hF0;
	localparam logic [7:0] PFX_LEAD3  = 8'hE0;
	localparam logic [7:0] MASK_LEAD4 = 8'hF8;
	localparam logic [7:0] PFX_LEAD4  = 8'hF0;

	localparam int CP_W    = 21;
	localparam int LEN_W   = 3;
	localparam int BITS_W  = 7;
	localparam int CONT_W  = 6;

	// Queue between classifier and assembler
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		K_ASCII,
		K_BAD,
		K_LEAD,
		K_CONT,
		K_LAST
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [LEN_W-1:0]   len;
		logic [BITS_W-1:0]  bits;
	} entry_t;

endpackage

// ===== sv/u8dec_front.sv =====
// Byte classifier: tracks sequence position and tags each byte for the assembler.
`timescale 1ns / 1ps

module u8dec_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  logic [7:0]          in_byte,
	input  logic                q_full,
	output logic                q_push,
	output u8dec_pkg::entry_t   q_entry
);

	logic [1:0] bytes_left_q;
	logic [1:0] bytes_left_nxt;

	assign byte_ready = !q_full;
	assign q_push     = byte_valid && byte_ready;

	always_comb begin
		q_entry        = '0;
		bytes_left_nxt = bytes_left_q;
		if (bytes_left_q != 2'd0) begin
			// inside a sequence every byte counts as continuation, top bits ignored
			q_entry.kind   = (bytes_left_q == 2'd1) ? u8dec_pkg::K_LAST : u8dec_pkg::K_CONT;
			q_entry.len    = 3'd0;
			q_entry.bits   = {1'b0, in_byte[5:0]};
			bytes_left_nxt = bytes_left_q - 2'd1;
		end else if ((in_byte & u8dec_pkg::MASK_ASCII) == u8dec_pkg::PFX_ASCII) begin
			q_entry.kind = u8dec_pkg::K_ASCII;
			q_entry.len  = 3'd1;
			q_entry.bits = in_byte[6:0];
		end else if ((in_byte & u8dec_pkg::MASK_LEAD2) == u8dec_pkg::PFX_LEAD2) begin
			q_entry.kind   = u8dec_pkg::K_LEAD;
			q_entry.len    = 3'd2;
			q_entry.bits   = {2'b00, in_byte[4:0]};
			bytes_left_nxt = 2'd1;
		end else if ((in_byte & u8dec_pkg::MASK_LEAD3) == u8dec_pkg::PFX_LEAD3) begin
			q_entry.kind   = u8dec_pkg::K_LEAD;
			q_entry.len    = 3'd3;
			q_entry.bits   = {3'b000, in_byte[3:0]};
			bytes_left_nxt = 2'd2;
		end else if ((in_byte & u8dec_pkg::MASK_LEAD4) == u8dec_pkg::PFX_LEAD4) begin
			q_entry.kind   = u8dec_pkg::K_LEAD;
			q_entry.len    = 3'd4;
			q_entry.bits   = {4'b0000, in_byte[2:0]};
			bytes_left_nxt = 2'd3;
		end else begin
			q_entry.kind = u8dec_pkg::K_BAD;
			q_entry.len  = 3'd1;
			q_entry.bits = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
		end else if (q_push) begin
			bytes_left_q <= bytes_left_nxt;
		end
	end

endmodule

// ===== sv/u8dec_fifo.sv =====
// Short queue of classified bytes between classifier and assembler.
`timescale 1ns / 1ps

module u8dec_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8dec_pkg::entry_t   wr_entry,
	input  logic                pop,
	output u8dec_pkg::entry_t   rd_entry,
	output logic                full,
	output logic                empty
);

	u8dec_pkg::entry_t                  slot_q [u8dec_pkg::QDEPTH];
	logic [u8dec_pkg::QAW-1:0]          wr_ptr_q;
	logic [u8dec_pkg::QAW-1:0]          rd_ptr_q;
	logic [u8dec_pkg::QCNT_W-1:0]       cnt_q;

	assign full     = (cnt_q == u8dec_pkg::QCNT_W'(u8dec_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/u8dec_back.sv =====
// Code point assembler with registered output stage.
`timescale 1ns / 1ps

module u8dec_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  u8dec_pkg::entry_t                   q_entry,
	output logic                                q_pop,
	output logic                                cp_valid,
	input  logic                                cp_ready,
	output logic [u8dec_pkg::CP_W-1:0]          code_point,
	output logic [u8dec_pkg::LEN_W-1:0]         seq_length,
	output logic                                bad_lead
);

	logic [u8dec_pkg::CP_W-1:0]     accum_q;
	logic [u8dec_pkg::LEN_W-1:0]    len_q;
	logic                           out_valid_q;
	logic [u8dec_pkg::CP_W-1:0]     cp_q;
	logic [u8dec_pkg::LEN_W-1:0]    seq_len_q;
	logic                           bad_q;
	logic [u8dec_pkg::CP_W-1:0]     shifted;
	logic                           out_load;

	// output slot frees up when empty or being taken this cycle
	assign q_pop   = !q_empty && (!out_valid_q || cp_ready);
	assign shifted = {accum_q[u8dec_pkg::CP_W-u8dec_pkg::CONT_W-1:0],
		q_entry.bits[u8dec_pkg::CONT_W-1:0]};
	assign out_load = q_pop && (q_entry.kind == u8dec_pkg::K_ASCII ||
		q_entry.kind == u8dec_pkg::K_BAD || q_entry.kind == u8dec_pkg::K_LAST);

	assign cp_valid   = out_valid_q;
	assign code_point = cp_q;
	assign seq_length = seq_len_q;
	assign bad_lead   = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			accum_q     <= '0;
			len_q       <= '0;
			cp_q        <= '0;
			seq_len_q   <= '0;
			bad_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (cp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (q_entry.kind)
					u8dec_pkg::K_ASCII: begin
						cp_q        <= u8dec_pkg::CP_W'(q_entry.bits);
						seq_len_q   <= q_entry.len;
						bad_q       <= 1'b0;
					end
					u8dec_pkg::K_BAD: begin
						cp_q        <= '0;
						seq_len_q   <= q_entry.len;
						bad_q       <= 1'b1;
					end
					u8dec_pkg::K_LEAD: begin
						accum_q <= u8dec_pkg::CP_W'(q_entry.bits);
						len_q   <= q_entry.len;
					end
					u8dec_pkg::K_CONT: begin
						accum_q <= shifted;
					end
					u8dec_pkg::K_LAST: begin
						cp_q        <= shifted;
						seq_len_q   <= len_q;
						bad_q       <= 1'b0;
						accum_q     <= '0;
						len_q       <= '0;
					end
					default: begin
						accum_q <= accum_q;
					end
				endcase
			end
		end
	end

endmodule

// ===== sv/utf8_stream_decoder.sv =====
// Top level of the byte-serial UTF-8 decoder.
//
// Input channel: one raw byte per transfer on in_byte (byte_valid/byte_ready).
// Output channel: one result per completed sequence (cp_valid/cp_ready) with
// code_point, seq_length and bad_lead. A byte with the shape of a
// continuation or a 11111xxx byte, seen where a lead is expected, gives a
// result with bad_lead set, code_point 0 and seq_length 1.
// Continuation bytes are not checked; overlong forms pass through.
// Throughput: one byte per cycle while the queue is not full, set by the
// classifier and the assembler each handling one byte a cycle.
// The result of a sequence's last byte goes through the queue write and
// then the output register before it is valid.
// A four-entry queue sits between the classifier and the assembler. When the
// receiver holds cp_ready low the result register holds, the queue fills,
// and byte_ready drops once it is full.
// Reset (arst_n low) empties the queue and the output register and returns
// the decoder to expecting a lead byte.
`timescale 1ns / 1ps

module utf8_stream_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_ready,
	input  logic [7:0]                          in_byte,
	output logic                                cp_valid,
	input  logic                                cp_ready,
	output logic [u8dec_pkg::CP_W-1:0]          code_point,
	output logic [u8dec_pkg::LEN_W-1:0]         seq_length,
	output logic                                bad_lead
);

	u8dec_pkg::entry_t  wr_entry;
	u8dec_pkg::entry_t  rd_entry;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;

	u8dec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.in_byte    (in_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (wr_entry)
	);

	u8dec_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	u8dec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_entry    (rd_entry),
		.q_pop      (q_pop),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.code_point (code_point),
		.seq_length (seq_length),
		.bad_lead   (bad_lead)
	);

endmodule

// ===== sv/u8dec_checker.sv =====
// Port-level assertions for the UTF-8 decoder, bound to the top level.
`timescale 1ns / 1ps

module u8dec_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cp_valid,
	input  logic                                cp_ready,
	input  logic [u8dec_pkg::CP_W-1:0]          code_point,
	input  logic [u8dec_pkg::LEN_W-1:0]         seq_length,
	input  logic                                bad_lead
);

	// error results carry a fixed shape
	a_bad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && bad_lead |-> code_point == '0 && seq_length == 3'd1)
		else $error("bad lead result with nonzero code point or length");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid |-> seq_length == 3'd1 || seq_length == 3'd2 ||
			seq_length == 3'd3 || seq_length == 3'd4)
		else $error("sequence length out of range");

	// payload width follows from the length
	a_cp_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && !bad_lead |->
			(seq_length == 3'd1 && code_point < 21'd128) ||
			(seq_length == 3'd2 && code_point < 21'd2048) ||
			(seq_length == 3'd3 && code_point < 21'd65536) ||
			seq_length == 3'd4)
		else $error("code point too wide for its sequence length");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && !cp_ready |=> cp_valid && $stable(code_point) &&
			$stable(seq_length) && $stable(bad_lead))
		else $error("stalled result changed");

endmodule

bind utf8_stream_decoder u8dec_checker u_chk (.*);
